// File: design/kmeans_iteration_engine_assert.svh
// assertion macros for the top-level design file kmeans_iteration_engine.sv
`ifndef KMEANS_ITERATION_ENGINE_ASSERT_SVH
`define KMEANS_ITERATION_ENGINE_ASSERT_SVH

`ifndef SYNTH
// a holds in a cycle, then b holds in that cycle
`define KIE_ASSERT_NOW(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// a holds in a cycle, then b holds in the next one
`define KIE_ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define KIE_ASSERT_NOW(lbl, a, b, msg)
`define KIE_ASSERT_NEXT(lbl, a, b, msg)
`endif

`endif

// File: design/kie_pkg.sv
package kie_pkg;

  localparam int COORD_W    = 16;
  localparam int CFG_W      = 16;
  localparam int DIST_W     = 38;
  localparam int OUT_DIST_W = 37;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_POINT  = 2'd1;
  localparam logic [1:0] FUNC_UPDATE = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  localparam logic [1:0] KIND_ASSIGN = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [1:0] CFG_CLUSTER_COUNT  = 2'd0;
  localparam logic [1:0] CFG_DIMS_IN_USE    = 2'd1;
  localparam logic [1:0] CFG_MOVE_THRESHOLD = 2'd2;

  typedef struct packed {
    logic [1:0]                func;
    logic [3:0]                cluster_index;
    logic [4:0]                dim_index;
    logic signed [COORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                kind;
    logic [3:0]                cluster;
    logic [OUT_DIST_W-1:0]     min_distance;
    logic                      converged;
    logic signed [COORD_W-1:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic square;
    logic accum;
    logic clear;
  } cell_ctrl_t;

endpackage

// File: design/kie_ram.sv
module kie_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/kie_cell.sv
module kie_cell import kie_pkg::*; #(
  parameter int CELL_IDX = 0,
  parameter int IDX_W    = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cell_ctrl_t          ctrl,
  input  logic                active,
  input  logic [COORD_W-1:0]  coord_in,
  input  logic [COORD_W-1:0]  point_val,
  output logic [COORD_W-1:0]  coord_out,
  input  logic [DIST_W-1:0]   cand_dist_in,
  input  logic [IDX_W-1:0]    cand_idx_in,
  output logic [DIST_W-1:0]   cand_dist_out,
  output logic [IDX_W-1:0]    cand_idx_out
);

  logic [COORD_W-1:0]   coord_r;
  logic [2*COORD_W-1:0] sq_r;
  logic [DIST_W-1:0]    acc_r;
  logic [DIST_W-1:0]    cand_dist_r;
  logic [IDX_W-1:0]     cand_idx_r;

  logic signed [COORD_W:0] diff;
  logic [COORD_W-1:0]      mag;
  logic [DIST_W:0]         acc_sum;

  assign diff = $signed({coord_r[COORD_W-1], coord_r}) -
                $signed({point_val[COORD_W-1], point_val});
  assign mag  = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
  assign acc_sum = {1'b0, acc_r} + (DIST_W + 1)'(sq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctrl.clear) begin
      acc_r <= '0;
    end else if (ctrl.accum && active) begin
      // saturate the running distance
      acc_r <= acc_sum[DIST_W] ? {DIST_W{1'b1}} : acc_sum[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      coord_r <= coord_in;
    end
    if (ctrl.square) begin
      sq_r <= mag * mag;
    end
    // strict compare keeps the lower index on ties
    if (active && (acc_r < cand_dist_in)) begin
      cand_dist_r <= acc_r;
      cand_idx_r  <= IDX_W'(CELL_IDX);
    end else begin
      cand_dist_r <= cand_dist_in;
      cand_idx_r  <= cand_idx_in;
    end
  end

  assign coord_out     = coord_r;
  assign cand_dist_out = cand_dist_r;
  assign cand_idx_out  = cand_idx_r;

endmodule

// File: design/kie_divider.sv
module kie_divider #(
  parameter int DW = 33,
  parameter int VW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_r;
  logic          done_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] div_r;

  logic [VW:0] trial;
  logic        take;

  assign trial = {rem_r, quo_r[DW-1]};
  assign take  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CW'(DW);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CW'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[DW-2:0], take};
      rem_r <= take ? VW'(trial - {1'b0, div_r}) : trial[VW-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: design/kmeans_iteration_engine.sv
// one Lloyd k-means iteration engine. commands are taken when start is high and busy is low;
// every result is shown for exactly one cycle with out_strobe and must be caught then, since
// the receiver cannot stall the block. a centroid load costs no busy time. a read is answered
// from the centroid memory via the S_READ state. a point coordinate keeps the block busy while
// the centroid column moves one cluster a cycle from the centroid memory into the cell row,
// then for a square and an accumulate step in every cell; the last coordinate adds the minimum
// sweep down the row and, unless the chosen cluster is full, a pass adding the point into its
// cluster's sums. an update steps through the active clusters and, for each one with members,
// forms the mean of every coordinate with the bit-serial divider.
// no clearing pass follows reset: each cluster keeps a fill count of the sum coordinates
// written in this iteration, and a sum coordinate at or beyond it counts as zero
`include "kmeans_iteration_engine_assert.svh"

module kmeans_iteration_engine import kie_pkg::*; #(
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_DIMS     = 32,
  parameter int MAX_POINTS   = 65536
) (
  input  logic       clk,
  input  logic       rst_n,
  // command side
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  // result side
  output logic       out_strobe,
  output out_item_t  out_item,
  // register writes
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CL_W  = $clog2(MAX_CLUSTERS);
  localparam int DM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DEPTH = MAX_CLUSTERS * MAX_DIMS;
  localparam int A_W   = $clog2(DEPTH);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = COORD_W + $clog2(MAX_POINTS) + 1;
  localparam int K_W   = $clog2(MAX_CLUSTERS + 1);
  localparam int D_W   = $clog2(MAX_DIMS + 1);
  localparam int CT_W  = $clog2(((MAX_CLUSTERS > MAX_DIMS) ? MAX_CLUSTERS : MAX_DIMS) + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_SQ, S_ACC, S_MIN, S_SUM,
    S_UPD_ROW, S_UPD_RD, S_UPD_LAT, S_UPD_DIV, S_READ
  } state_t;

  function automatic logic [A_W-1:0] tab_addr(input int c, input int j);
    return A_W'(c * MAX_DIMS + j);
  endfunction

  // registers
  logic [4:0]         cluster_count_r;
  logic [5:0]         dims_r;
  logic [CFG_W-1:0]   thresh_r;

  state_t             state_r, state_nxt;
  logic [CT_W-1:0]    cnt_r, cnt_nxt;
  logic [4:0]         di_r, di_nxt;
  logic [COORD_W-1:0] val_r, val_nxt;
  logic               last_r, last_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic [CL_W-1:0]    best_r, best_nxt;
  logic [K_W-1:0]     uc_r, uc_nxt;
  logic [D_W-1:0]     j_r, j_nxt;
  logic               conv_r, conv_nxt;
  logic               neg_r, neg_nxt;
  logic [COORD_W-1:0] old_r, old_nxt;
  logic [CNT_W-1:0]   member_cnt_r [MAX_CLUSTERS];
  logic [CNT_W-1:0]   member_cnt_nxt [MAX_CLUSTERS];
  logic [D_W-1:0]     fill_r [MAX_CLUSTERS];
  logic [D_W-1:0]     fill_nxt [MAX_CLUSTERS];
  logic               out_strobe_r, out_strobe_nxt;
  out_item_t          out_item_r, out_item_nxt;

  // clamped register values
  logic [K_W-1:0] k_eff;
  logic [D_W-1:0] d_eff;

  always_comb begin
    if (cluster_count_r == '0) begin
      k_eff = K_W'(1);
    end else if (int'(cluster_count_r) > MAX_CLUSTERS) begin
      k_eff = K_W'(MAX_CLUSTERS);
    end else begin
      k_eff = K_W'(cluster_count_r);
    end
    if (dims_r == '0) begin
      d_eff = D_W'(1);
    end else if (int'(dims_r) > MAX_DIMS) begin
      d_eff = D_W'(MAX_DIMS);
    end else begin
      d_eff = D_W'(dims_r);
    end
  end

  // memories and the cell row
  logic               cent_we;
  logic [A_W-1:0]     cent_waddr, cent_raddr;
  logic [COORD_W-1:0] cent_wdata, cent_rdata;
  logic               sum_we;
  logic [A_W-1:0]     sum_waddr, sum_raddr;
  logic [SUM_W-1:0]   sum_wdata, sum_rdata;
  logic               pt_we;
  logic [DM_W-1:0]    pt_waddr, pt_raddr;
  logic [COORD_W-1:0] pt_rdata;

  cell_ctrl_t         cell_ctrl;
  logic               div_start, div_done;
  logic [SUM_W-1:0]   div_dividend, div_quotient;

  logic [COORD_W-1:0] chain_coord [MAX_CLUSTERS+1];
  logic [DIST_W-1:0]  chain_dist  [MAX_CLUSTERS+1];
  logic [CL_W-1:0]    chain_idx   [MAX_CLUSTERS+1];

  kie_ram #(.WIDTH(COORD_W), .DEPTH(DEPTH)) u_cent_ram (
    .clk, .we(cent_we), .waddr(cent_waddr), .wdata(cent_wdata),
    .raddr(cent_raddr), .rdata(cent_rdata)
  );

  kie_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_sum_ram (
    .clk, .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
    .raddr(sum_raddr), .rdata(sum_rdata)
  );

  kie_ram #(.WIDTH(COORD_W), .DEPTH(MAX_DIMS)) u_pt_ram (
    .clk, .we(pt_we), .waddr(pt_waddr), .wdata(in_item.value),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  // the column fetched from memory enters at cell 0; the minimum search runs the same way
  assign chain_coord[0] = cent_rdata;
  assign chain_dist[0]  = {DIST_W{1'b1}};
  assign chain_idx[0]   = '0;

  for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_cell
    kie_cell #(.CELL_IDX(i), .IDX_W(CL_W)) u_cell (
      .clk, .rst_n,
      .ctrl(cell_ctrl),
      .active(i < int'(k_eff)),
      .coord_in(chain_coord[i]),
      .point_val(val_r),
      .coord_out(chain_coord[i+1]),
      .cand_dist_in(chain_dist[i]),
      .cand_idx_in(chain_idx[i]),
      .cand_dist_out(chain_dist[i+1]),
      .cand_idx_out(chain_idx[i+1])
    );
  end

  kie_divider #(.DW(SUM_W), .VW(CNT_W)) u_div (
    .clk, .rst_n,
    .start(div_start),
    .dividend(div_dividend),
    .divisor(member_cnt_r[CL_W'(uc_r)]),
    .done(div_done),
    .quotient(div_quotient)
  );

  logic                  accept;
  logic                  in_ok;
  logic                  pt_in_use;
  logic                  assign_out;
  logic [CL_W-1:0]       sel_c;
  logic [CNT_W-1:0]      sel_cnt;
  logic [CT_W-1:0]       sum_col;
  logic [SUM_W-1:0]      sum_base;
  logic signed [SUM_W:0]   mean;
  logic signed [SUM_W+1:0] move;
  logic [SUM_W+1:0]        move_mag;
  logic [DIST_W-1:0]     best_dist;

  assign accept = start && !busy;
  assign in_ok  = (int'(in_item.cluster_index) < MAX_CLUSTERS) &&
                  (int'(in_item.dim_index) < MAX_DIMS);
  assign pt_in_use = accept && (in_item.func == FUNC_POINT) &&
                     (int'(in_item.dim_index) < int'(d_eff));
  assign assign_out = out_strobe && (out_item.kind == KIND_ASSIGN);
  assign sel_c  = (state_r == S_SUM) ? best_r : CL_W'(uc_r);
  assign sel_cnt = member_cnt_r[sel_c];
  // coordinate of the sum word now on the read port
  assign sum_col  = (state_r == S_SUM) ? (cnt_r - CT_W'(1)) : CT_W'(j_r);
  // sums at or past the row's fill count are stale and count as zero
  assign sum_base = (int'(sum_col) < int'(fill_r[sel_c])) ? sum_rdata : '0;
  assign mean     = neg_r ? -$signed({1'b0, div_quotient}) : $signed({1'b0, div_quotient});
  assign move     = (SUM_W + 2)'(mean) - (SUM_W + 2)'($signed(old_r));
  assign move_mag = move[SUM_W+1] ? (SUM_W + 2)'(-move) : move;
  assign best_dist = chain_dist[MAX_CLUSTERS];

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    di_nxt         = di_r;
    val_nxt        = val_r;
    last_nxt       = last_r;
    rd_ok_nxt      = rd_ok_r;
    best_nxt       = best_r;
    uc_nxt         = uc_r;
    j_nxt          = j_r;
    conv_nxt       = conv_r;
    neg_nxt        = neg_r;
    old_nxt        = old_r;
    member_cnt_nxt = member_cnt_r;
    fill_nxt       = fill_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;

    cent_we      = 1'b0;
    cent_waddr   = tab_addr(int'(in_item.cluster_index), int'(in_item.dim_index));
    cent_wdata   = in_item.value;
    cent_raddr   = tab_addr(int'(in_item.cluster_index), int'(in_item.dim_index));
    sum_we       = 1'b0;
    sum_waddr    = tab_addr(int'(best_r), int'(cnt_r) - 1);
    sum_wdata    = sum_base + SUM_W'($signed(pt_rdata));
    sum_raddr    = tab_addr(int'(best_r), int'(cnt_r));
    pt_we        = 1'b0;
    pt_waddr     = DM_W'(in_item.dim_index);
    pt_raddr     = DM_W'(cnt_r);
    cell_ctrl    = '0;
    div_start    = 1'b0;
    div_dividend = sum_base[SUM_W-1] ? SUM_W'(-sum_base) : sum_base;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.func)
            FUNC_LOAD: begin
              cent_we = in_ok;
            end
            FUNC_POINT: begin
              // coordinates beyond the active dimensions are dropped
              if (int'(in_item.dim_index) < int'(d_eff)) begin
                pt_we     = 1'b1;
                di_nxt    = in_item.dim_index;
                val_nxt   = in_item.value;
                last_nxt  = (int'(in_item.dim_index) == int'(d_eff) - 1);
                cnt_nxt   = '0;
                state_nxt = S_FETCH;
              end
            end
            FUNC_UPDATE: begin
              uc_nxt    = '0;
              conv_nxt  = 1'b1;
              state_nxt = S_UPD_ROW;
            end
            default: begin
              rd_ok_nxt = in_ok;
              state_nxt = S_READ;
            end
          endcase
        end
      end

      S_FETCH: begin
        // highest cluster first, so that each lands in its own cell
        cent_raddr      = tab_addr(MAX_CLUSTERS - 1 - int'(cnt_r), int'(di_r));
        cell_ctrl.shift = (cnt_r != '0);
        cnt_nxt         = cnt_r + CT_W'(1);
        if (int'(cnt_r) == MAX_CLUSTERS) begin
          state_nxt = S_SQ;
        end
      end

      S_SQ: begin
        cell_ctrl.square = 1'b1;
        state_nxt        = S_ACC;
      end

      S_ACC: begin
        cell_ctrl.accum = 1'b1;
        cnt_nxt         = '0;
        state_nxt       = last_r ? S_MIN : S_IDLE;
      end

      S_MIN: begin
        cnt_nxt = cnt_r + CT_W'(1);
        if (int'(cnt_r) == MAX_CLUSTERS) begin
          best_nxt        = chain_idx[MAX_CLUSTERS];
          cell_ctrl.clear = 1'b1;
          out_strobe_nxt  = 1'b1;
          out_item_nxt    = '0;
          out_item_nxt.kind    = KIND_ASSIGN;
          out_item_nxt.cluster = 4'(chain_idx[MAX_CLUSTERS]);
          out_item_nxt.min_distance = (best_dist > DIST_W'({OUT_DIST_W{1'b1}})) ?
                                      {OUT_DIST_W{1'b1}} : best_dist[OUT_DIST_W-1:0];
          cnt_nxt = '0;
          // a full cluster still takes the assignment but no longer sums
          if (int'(member_cnt_r[chain_idx[MAX_CLUSTERS]]) < MAX_POINTS) begin
            state_nxt = S_SUM;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_SUM: begin
        // read one coordinate a cycle, write it back added in the next cycle
        sum_we  = (cnt_r != '0);
        cnt_nxt = cnt_r + CT_W'(1);
        if (int'(cnt_r) == int'(d_eff)) begin
          member_cnt_nxt[best_r] = member_cnt_r[best_r] + CNT_W'(1);
          if (d_eff > fill_r[best_r]) begin
            fill_nxt[best_r] = d_eff;
          end
          state_nxt = S_IDLE;
        end
      end

      S_UPD_ROW: begin
        j_nxt = '0;
        if (uc_r == k_eff) begin
          for (int c = 0; c < MAX_CLUSTERS; c++) begin
            member_cnt_nxt[c] = '0;
            fill_nxt[c]       = '0;
          end
          cell_ctrl.clear = 1'b1;
          out_strobe_nxt  = 1'b1;
          out_item_nxt    = '0;
          out_item_nxt.kind      = KIND_UPDATE;
          out_item_nxt.converged = conv_r;
          state_nxt = S_IDLE;
        end else if (sel_cnt == '0) begin
          uc_nxt = uc_r + K_W'(1);
        end else begin
          state_nxt = S_UPD_RD;
        end
      end

      S_UPD_RD: begin
        cent_raddr = tab_addr(int'(uc_r), int'(j_r));
        sum_raddr  = tab_addr(int'(uc_r), int'(j_r));
        state_nxt  = S_UPD_LAT;
      end

      S_UPD_LAT: begin
        div_start = 1'b1;
        neg_nxt   = sum_base[SUM_W-1];
        old_nxt   = cent_rdata;
        state_nxt = S_UPD_DIV;
      end

      S_UPD_DIV: begin
        if (div_done) begin
          cent_we    = 1'b1;
          cent_waddr = tab_addr(int'(uc_r), int'(j_r));
          cent_wdata = mean[COORD_W-1:0];
          if (move_mag > (SUM_W + 2)'(thresh_r)) begin
            conv_nxt = 1'b0;
          end
          j_nxt = j_r + D_W'(1);
          if (int'(j_r) == int'(d_eff) - 1) begin
            uc_nxt    = uc_r + K_W'(1);
            state_nxt = S_UPD_ROW;
          end else begin
            state_nxt = S_UPD_RD;
          end
        end
      end

      S_READ: begin
        out_strobe_nxt  = 1'b1;
        out_item_nxt    = '0;
        out_item_nxt.kind       = KIND_READ;
        out_item_nxt.read_value = rd_ok_r ? cent_rdata : '0;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      cnt_r           <= '0;
      out_strobe_r    <= 1'b0;
      cluster_count_r <= 5'd2;
      dims_r          <= 6'd32;
      thresh_r        <= '0;
      for (int c = 0; c < MAX_CLUSTERS; c++) begin
        member_cnt_r[c] <= '0;
        fill_r[c]       <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
      member_cnt_r <= member_cnt_nxt;
      fill_r       <= fill_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CLUSTER_COUNT:  cluster_count_r <= cfg_data[4:0];
          CFG_DIMS_IN_USE:    dims_r          <= cfg_data[5:0];
          CFG_MOVE_THRESHOLD: thresh_r        <= cfg_data;
          default: ;
        endcase
      end
    end
    di_r       <= di_nxt;
    val_r      <= val_nxt;
    last_r     <= last_nxt;
    rd_ok_r    <= rd_ok_nxt;
    best_r     <= best_nxt;
    uc_r       <= uc_nxt;
    j_r        <= j_nxt;
    conv_r     <= conv_nxt;
    neg_r      <= neg_nxt;
    old_r      <= old_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // result strobes never come back to back
  `KIE_ASSERT_NEXT(a_strobe_gap, out_strobe, !out_strobe, "back-to-back result strobes")
  // a point coordinate that is in use always makes the block busy
  `KIE_ASSERT_NEXT(a_point_busy, pt_in_use, busy, "point transfer did not start work")
  // an assignment names an active cluster
  `KIE_ASSERT_NOW(a_assign_active, assign_out, int'(out_item.cluster) < int'(k_eff), "bad cluster")
  // the divider only finishes while an update waits for it
  `KIE_ASSERT_NOW(a_div_owner, div_done, state_r == S_UPD_DIV, "divider result with no update waiting")

endmodule
